// File: design/ncd_pkg.sv
`default_nettype none
package ncd_pkg;
    localparam int NODE_W  = 4;
    localparam int W_W     = 32;
    localparam int DIST_W  = 40;
    localparam int CNT_W   = 5;
    localparam int MAX_NODES_D  = 16;
    localparam int MAX_DEGREE_D = 16;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_UPDATE = 2'd1,
        OP_RUN    = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD_RD,
        S_UPD_WAIT,
        S_UPD_CHK,
        S_RUN_INIT,
        S_EDGE_RD,
        S_EDGE_WAIT,
        S_EDGE_EVAL,
        S_PAR_B,
        S_PAR_C,
        S_DONE
    } t_state;

    typedef struct packed {
        logic relax;
    } t_relax;
endpackage
`default_nettype wire

// File: design/ncd_if.sv
`default_nettype none
interface ncd_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                operation;
    logic [ncd_pkg::NODE_W-1:0] src_node;
    logic [ncd_pkg::NODE_W-1:0] dst_node;
    logic signed [ncd_pkg::W_W-1:0] weight;
    modport source (output valid, operation, src_node, dst_node, weight, input ready);
    modport sink (input valid, operation, src_node, dst_node, weight, output ready);
endinterface

interface ncd_out_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic                      negative_cycle;
    logic [ncd_pkg::NODE_W-1:0] cycle_node_a;
    logic [ncd_pkg::NODE_W-1:0] cycle_node_b;
    logic [ncd_pkg::NODE_W-1:0] cycle_node_c;
    modport source (output valid, status, negative_cycle, cycle_node_a, cycle_node_b,
                    cycle_node_c, input ready);
    modport sink (input valid, status, negative_cycle, cycle_node_a, cycle_node_b,
                  cycle_node_c, output ready);
endinterface
`default_nettype wire

// File: design/ncd_relax.sv
`default_nettype none
module ncd_relax (
    input  wire logic                              i_u_reached,
    input  wire logic                              i_v_reached,
    input  wire logic signed [ncd_pkg::DIST_W-1:0] i_du,
    input  wire logic signed [ncd_pkg::DIST_W-1:0] i_dv,
    input  wire logic signed [ncd_pkg::W_W-1:0]    i_w,
    output logic signed [ncd_pkg::DIST_W-1:0]      o_sum_sat,
    output ncd_pkg::t_relax                        o_res
);
    import ncd_pkg::*;
    logic signed [DIST_W:0] sum;
    always_comb begin
        sum = {i_du[DIST_W-1], i_du} + (DIST_W+1)'(i_w);
        if (sum[DIST_W] != sum[DIST_W-1])
            o_sum_sat = sum[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
        else
            o_sum_sat = sum[DIST_W-1:0];
        o_res.relax = i_u_reached && (!i_v_reached || (sum < $signed({i_dv[DIST_W-1], i_dv})));
    end
endmodule
`default_nettype wire

// File: design/negative_cycle_detector.sv
// channel | dir | payload
// in      | in  | operation, src_node, dst_node, weight
// out     | out | status, negative_cycle, cycle_node_a..c
// cfg     | in  | APB, node_count at 0x0
// Append, clear, bad index: result the cycle after acceptance.
// Update: walks the stored edges of src, setting the weight of each match.
// Run: up to node_count-1 relaxation passes over the edges, then a check pass,
// all through the single relax unit and the one-port edge memory.
// Not ready from acceptance until the result is taken. Sync active-low reset.
`default_nettype none
module negative_cycle_detector #(
    parameter int MAX_NODES  = ncd_pkg::MAX_NODES_D,
    parameter int MAX_DEGREE = ncd_pkg::MAX_DEGREE_D
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ncd_in_if.sink    i_in,
    ncd_out_if.source o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ncd_pkg::*;
    localparam int NB = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int KB = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int DB = $clog2(MAX_DEGREE + 1);
    localparam int NCB = $clog2(MAX_NODES + 1);

    logic [CNT_W-1:0] r_cnt;
    assign pready = 1'b1;
    assign prdata = {{(32-CNT_W){1'b0}}, r_cnt};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cnt <= CNT_RESET;
        else if (psel && penable && pwrite && paddr == 2'd0) r_cnt <= pwdata[CNT_W-1:0];
    end
    logic [NCB-1:0] live;
    always_comb begin
        if (32'(r_cnt) > MAX_NODES) live = NCB'(MAX_NODES);
        else live = NCB'(r_cnt);
    end

    logic [NODE_W-1:0] mem_dst [MAX_NODES*MAX_DEGREE];
    logic signed [W_W-1:0] mem_w [MAX_NODES*MAX_DEGREE];
    logic [NODE_W-1:0] r_rd_dst;
    logic signed [W_W-1:0] r_rd_w;
    logic [NB+KB-1:0] mem_addr;
    logic mem_we, mem_wd;
    logic [NODE_W-1:0] mem_wdst;

    logic [DB-1:0] r_deg [MAX_NODES];
    logic signed [DIST_W-1:0] r_dist [MAX_NODES];
    logic [MAX_NODES-1:0] r_reach;
    logic [NODE_W-1:0] r_par [MAX_NODES];

    t_state r_st, n_st;
    logic [NODE_W-1:0] r_src, r_dst;
    logic signed [W_W-1:0] r_w;
    logic [NB-1:0] r_u;
    logic [KB:0] r_k;
    logic [NCB-1:0] r_pass;
    logic r_changed, r_check;
    logic r_ov;
    logic [1:0] r_status;
    logic r_neg;
    logic [NODE_W-1:0] r_a, r_b, r_c;

    logic signed [DIST_W-1:0] sum_sat;
    t_relax rel;
    logic [NB-1:0] vi;
    logic v_ok;
    assign vi = r_rd_dst[NB-1:0];
    assign v_ok = (NCB'(r_rd_dst) < live) && (32'(r_rd_dst) < MAX_NODES);

    ncd_relax u_relax (
        .i_u_reached(r_reach[r_u]), .i_v_reached(r_reach[vi]),
        .i_du(r_dist[r_u]), .i_dv(r_dist[vi]), .i_w(r_rd_w),
        .o_sum_sat(sum_sat), .o_res(rel)
    );
    logic do_relax;
    assign do_relax = v_ok && rel.relax;

    logic [DB-1:0] deg_u;
    assign deg_u = r_deg[r_u];
    logic edge_left;
    assign edge_left = (DB+1)'(r_k) < (DB+1)'(deg_u);
    logic last_u;
    assign last_u = (NCB'(r_u) + 1'b1) >= live;

    logic in_bad;
    logic acc;
    assign acc = i_in.valid && i_in.ready;
    assign i_in.ready = (r_st == S_IDLE) && !r_ov;

    always_comb begin
        in_bad = (NCB'(i_in.src_node) >= live) || (32'(i_in.src_node) >= MAX_NODES) ||
            (i_in.operation != OP_RUN &&
             ((NCB'(i_in.dst_node) >= live) || (32'(i_in.dst_node) >= MAX_NODES)));
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (acc && t_op'(i_in.operation) != OP_CLEAR && !in_bad) begin
                if (t_op'(i_in.operation) == OP_UPDATE) n_st = S_UPD_RD;
                else if (t_op'(i_in.operation) == OP_RUN) n_st = S_RUN_INIT;
            end
            S_UPD_RD:   n_st = edge_left ? S_UPD_WAIT : S_IDLE;
            S_UPD_WAIT: n_st = S_UPD_CHK;
            S_UPD_CHK:  n_st = S_UPD_RD;
            S_RUN_INIT: n_st = S_EDGE_RD;
            S_EDGE_RD:  n_st = edge_left ? S_EDGE_WAIT : S_EDGE_RD;
            S_EDGE_WAIT: n_st = S_EDGE_EVAL;
            S_EDGE_EVAL: n_st = (r_check && do_relax) ? S_PAR_B : S_EDGE_RD;
            S_PAR_B:    n_st = S_PAR_C;
            S_PAR_C:    n_st = S_DONE;
            S_DONE:     n_st = S_IDLE;
            default:    n_st = S_IDLE;
        endcase
        if (r_st == S_EDGE_RD && !edge_left && last_u) begin
            if (r_check) n_st = S_DONE;
            else if (!r_changed || (r_pass + 2'd2) >= live) n_st = S_EDGE_RD;
        end
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wd = 1'b0;
        mem_wdst = r_dst;
        mem_addr = {r_u, r_k[KB-1:0]};
        if (r_st == S_IDLE) begin
            mem_addr = {i_in.src_node[NB-1:0], r_deg[i_in.src_node[NB-1:0]][KB-1:0]};
            mem_wdst = i_in.dst_node;
            mem_we = acc && !in_bad && t_op'(i_in.operation) == OP_APPEND &&
                     32'(r_deg[i_in.src_node[NB-1:0]]) < MAX_DEGREE;
        end else if (r_st == S_UPD_CHK) begin
            mem_addr = {r_u, r_k[KB-1:0] - 1'b1};
            mem_wd = r_rd_dst == r_dst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_dst[mem_addr] <= mem_wdst;
            mem_w[mem_addr] <= i_in.weight;
        end else if (mem_wd) begin
            mem_w[mem_addr] <= r_w;
        end
        if (r_st != S_UPD_WAIT && r_st != S_EDGE_WAIT) begin
            r_rd_dst <= mem_dst[mem_addr];
            r_rd_w <= mem_w[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
            r_reach <= '0;
            for (int i = 0; i < MAX_NODES; i++) begin
                r_deg[i] <= '0;
                r_par[i] <= '0;
            end
        end else begin
            r_st <= n_st;
            if (o_out.valid && o_out.ready) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: if (acc) begin
                    r_src <= i_in.src_node;
                    r_dst <= i_in.dst_node;
                    r_w <= i_in.weight;
                    r_u <= i_in.src_node[NB-1:0];
                    r_k <= '0;
                    r_neg <= 1'b0;
                    r_a <= '0; r_b <= '0; r_c <= '0;
                    if (t_op'(i_in.operation) == OP_CLEAR) begin
                        for (int i = 0; i < MAX_NODES; i++) r_deg[i] <= '0;
                        r_status <= ST_OK;
                        r_ov <= 1'b1;
                    end else if (in_bad) begin
                        r_status <= ST_BAD;
                        r_ov <= 1'b1;
                    end else if (t_op'(i_in.operation) == OP_APPEND) begin
                        r_ov <= 1'b1;
                        if (32'(r_deg[i_in.src_node[NB-1:0]]) >= MAX_DEGREE)
                            r_status <= ST_FULL;
                        else begin
                            r_status <= ST_OK;
                            r_deg[i_in.src_node[NB-1:0]] <=
                                r_deg[i_in.src_node[NB-1:0]] + 1'b1;
                        end
                    end else begin
                        r_status <= ST_OK;
                    end
                end
                S_UPD_RD: begin
                    if (edge_left) r_k <= r_k + 1'b1;
                    else r_ov <= 1'b1;
                end
                S_RUN_INIT: begin
                    r_reach <= {{(MAX_NODES-1){1'b0}}, 1'b1} << r_src[NB-1:0];
                    r_dist[r_src[NB-1:0]] <= '0;
                    for (int i = 0; i < MAX_NODES; i++) r_par[i] <= '0;
                    r_u <= '0;
                    r_k <= '0;
                    r_pass <= '0;
                    r_changed <= 1'b0;
                    r_check <= (live < 2'd2);
                end
                S_EDGE_RD: begin
                    if (edge_left) r_k <= r_k + 1'b1;
                    else begin
                        r_k <= '0;
                        if (last_u) begin
                            r_u <= '0;
                            r_changed <= 1'b0;
                            r_pass <= r_pass + 1'b1;
                            if (!r_changed || (r_pass + 2'd2) >= live) r_check <= 1'b1;
                        end else r_u <= r_u + 1'b1;
                    end
                end
                S_EDGE_EVAL: if (do_relax) begin
                    if (r_check) begin
                        r_neg <= 1'b1;
                        r_a <= NODE_W'(r_u);
                    end else begin
                        r_dist[vi] <= sum_sat;
                        r_reach[vi] <= 1'b1;
                        r_par[vi] <= NODE_W'(r_u);
                        r_changed <= 1'b1;
                    end
                end
                S_PAR_B: r_b <= r_par[r_a[NB-1:0]];
                S_PAR_C: r_c <= r_par[r_b[NB-1:0]];
                S_DONE: r_ov <= 1'b1;
                default: ;
            endcase
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.status = r_status;
    assign o_out.negative_cycle = r_neg;
    assign o_out.cycle_node_a = r_a;
    assign o_out.cycle_node_b = r_b;
    assign o_out.cycle_node_c = r_c;
endmodule
`default_nettype wire

// File: design/ncd_checker.sv
`default_nettype none
module ncd_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [1:0] status,
    input wire logic neg
);
    a_no_take_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("input taken with result pending");
    a_bad_no_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && status != 2'd0) |-> !neg) else $error("cycle on failed op");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> status != 2'd3) else $error("bad status");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

bind negative_cycle_detector ncd_checker u_ncd_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(i_in.valid), .in_ready(i_in.ready),
    .out_valid(o_out.valid), .out_ready(o_out.ready),
    .status(o_out.status), .neg(o_out.negative_cycle)
);
`default_nettype wire
